// ===== rtl/core/hpks_pkg.sv =====
// ============================================================================
// hpks_pkg: shared types and codes of the per-key update serializer
// Transfer payloads, operation and status codes, and the register map.
// ============================================================================
`default_nettype none

package hpks_pkg;

	// Operation codes carried in the kind field
	localparam logic [1:0] KIND_ENQ   = 2'd0;
	localparam logic [1:0] KIND_FIN   = 2'd1;
	localparam logic [1:0] KIND_ABORT = 2'd2;

	// Status codes returned with every result
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_FULL     = 2'd1;
	localparam logic [1:0] STAT_EMPTY    = 2'd2;
	localparam logic [1:0] STAT_MISMATCH = 2'd3;

	// Register map: 64-bit registers at 8-byte steps
	localparam int         APB_AW    = 4;
	localparam int         APB_DW    = 64;
	localparam int         REG_IDX_W = APB_AW - 3;
	localparam logic [REG_IDX_W-1:0] REG_SALT = 1'b0;

	// Width of the id fields on the ports
	localparam int         ID_PORT_W = 8;

	typedef struct packed {
		logic [1:0]           kind;
		logic [63:0]          key_high;
		logic [63:0]          key_low;
		logic [ID_PORT_W-1:0] update_id;
	} in_item_t;

	typedef struct packed {
		logic                 grant_valid;
		logic [ID_PORT_W-1:0] grant_id;
		logic [1:0]           status;
	} out_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/hpks_hash.sv =====
// ============================================================================
// hpks_hash: salted key fold into a bucket index
// XORs both key halves with the salt, folds shifted copies together and
// registers the low bits as the bucket of the accepted transfer.
// ============================================================================
`default_nettype none

module hpks_hash #(
	parameter int BUCKET_BITS = 4
) (
	input  wire logic                   clk,
	input  wire logic                   load,
	input  wire logic [63:0]            key_high,
	input  wire logic [63:0]            key_low,
	input  wire logic [63:0]            salt,
	output logic      [BUCKET_BITS-1:0] bucket
);

	localparam int SH2  = 2 * BUCKET_BITS;
	localparam int SH4  = 4 * BUCKET_BITS;
	localparam int SH6  = 6 * BUCKET_BITS;
	localparam int SH8  = 8 * BUCKET_BITS;
	localparam int SH10 = 10 * BUCKET_BITS;
	localparam int SH12 = 12 * BUCKET_BITS;

	logic [63:0]            key_x;
	logic [63:0]            fold;
	logic [BUCKET_BITS-1:0] bucket_q;

	// Fold the salted key; shifts past the word give zero
	always_comb begin
		key_x = key_high ^ key_low ^ salt;
		fold  = key_x ^ (key_x >> SH12) ^ (key_x >> SH10) ^ (key_x >> SH8)
		      ^ (key_x >> SH6) ^ (key_x >> SH4) ^ (key_x >> SH2);
	end

	// Capture the bucket of the accepted transfer
	always_ff @(posedge clk) begin
		if (load) begin
			bucket_q <= fold[BUCKET_BITS-1:0];
		end
	end

	assign bucket = bucket_q;

endmodule

`default_nettype wire

// ===== rtl/core/hpks_engine.sv =====
// ============================================================================
// hpks_engine: bucket queue sequencer over the id and queue-state memories
// Reads the bucket's head and count, then appends, pops or compacts the
// bucket's circular id queue with read-modify-write steps.
// ============================================================================
`default_nettype none

module hpks_engine #(
	parameter int BUCKET_BITS = 4,
	parameter int QUEUE_DEPTH = 4,
	parameter int ID_BITS     = 8
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [1:0]                kind,
	input  wire logic [((ID_BITS < hpks_pkg::ID_PORT_W) ? ID_BITS
	                    : hpks_pkg::ID_PORT_W)-1:0] id,
	input  wire logic [BUCKET_BITS-1:0]    bucket,
	output logic                           res_valid,
	input  wire logic                      res_ready,
	output hpks_pkg::out_item_t            res
);

	localparam int IDW = (ID_BITS < hpks_pkg::ID_PORT_W) ? ID_BITS : hpks_pkg::ID_PORT_W;
	localparam int NB  = 1 << BUCKET_BITS;
	localparam int NS  = NB * QUEUE_DEPTH;
	localparam int AW  = $clog2(NS);
	localparam int PW  = $clog2(QUEUE_DEPTH);
	localparam int CW  = $clog2(QUEUE_DEPTH + 1);
	localparam int SW  = CW + 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_META = 3'd1;
	localparam logic [2:0] ST_HEAD = 3'd2;
	localparam logic [2:0] ST_NEXT = 3'd3;
	localparam logic [2:0] ST_SCAN = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	typedef struct packed {
		logic [PW-1:0] head;
		logic [CW-1:0] cnt;
	} meta_t;

	// Position in the circular queue, head plus offset
	function automatic logic [PW-1:0] pos_add(input logic [PW-1:0] h, input logic [CW-1:0] i);
		logic [SW-1:0] s;
		s = SW'(h) + SW'(i);
		if (s >= SW'(QUEUE_DEPTH)) begin
			s = s - SW'(QUEUE_DEPTH);
		end
		return s[PW-1:0];
	endfunction

	// Memory address of a bucket slot
	function automatic logic [AW-1:0] slot_addr(input logic [BUCKET_BITS-1:0] b,
			input logic [PW-1:0] p);
		return AW'(b) * AW'(QUEUE_DEPTH) + AW'(p);
	endfunction

	// Memories
	logic [IDW-1:0] pend_mem [NS];
	meta_t          meta_mem [NB];
	logic [NB-1:0]  meta_vld_q;

	logic [IDW-1:0] pend_rdata_q;
	meta_t          meta_rdata_q;
	logic           meta_rvld_q;

	logic           pend_we;
	logic [AW-1:0]  pend_waddr;
	logic [IDW-1:0] pend_wdata;
	logic [AW-1:0]  pend_raddr;
	logic           meta_we;
	meta_t          meta_wdata;

	// Sequencer state
	logic [2:0]          state_q, state_d;
	logic [PW-1:0]       head_q, head_d;
	logic [CW-1:0]       cnt_q, cnt_d;
	logic [CW-1:0]       idx_q, idx_d;
	logic [CW-1:0]       kept_q, kept_d;
	hpks_pkg::out_item_t res_q, res_d;

	meta_t         meta_cur;
	logic [PW-1:0] pop_head;
	logic [CW-1:0] pop_cnt;
	logic          keep;
	logic [CW-1:0] kept_nx;
	logic [CW-1:0] idx_nx;

	// Id slot memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (pend_we) begin
			pend_mem[pend_waddr] <= pend_wdata;
		end
		pend_rdata_q <= pend_mem[pend_raddr];
	end

	// Queue-state memory: read at the current bucket, registered
	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[bucket] <= meta_wdata;
		end
		meta_rdata_q <= meta_mem[bucket];
	end

	// Valid bits: an unwritten bucket reads as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_vld_q  <= '0;
			meta_rvld_q <= 1'b0;
		end else begin
			if (meta_we) begin
				meta_vld_q[bucket] <= 1'b1;
			end
			meta_rvld_q <= meta_vld_q[bucket];
		end
	end

	// Step the sequencer
	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		cnt_d      = cnt_q;
		idx_d      = idx_q;
		kept_d     = kept_q;
		res_d      = res_q;
		pend_we    = 1'b0;
		pend_waddr = slot_addr(bucket, pos_add(head_q, kept_q));
		pend_wdata = pend_rdata_q;
		pend_raddr = slot_addr(bucket, head_q);
		meta_we    = 1'b0;
		meta_wdata = meta_t'{head: head_q, cnt: cnt_q};
		meta_cur   = meta_rvld_q ? meta_rdata_q : meta_t'('0);
		pop_head   = pos_add(head_q, CW'(1));
		pop_cnt    = cnt_q - CW'(1);
		keep       = pend_rdata_q != id;
		kept_nx    = keep ? kept_q + CW'(1) : kept_q;
		idx_nx     = idx_q + CW'(1);

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_META;
				end
			end
			ST_META: begin
				head_d            = meta_cur.head;
				cnt_d             = meta_cur.cnt;
				res_d             = '0;
				res_d.status      = hpks_pkg::STAT_OK;
				if (kind == hpks_pkg::KIND_ENQ) begin
					// Append unless full; grant at once into an empty queue
					if (meta_cur.cnt == CW'(QUEUE_DEPTH)) begin
						res_d.status = hpks_pkg::STAT_FULL;
					end else begin
						pend_we    = 1'b1;
						pend_waddr = slot_addr(bucket, pos_add(meta_cur.head, meta_cur.cnt));
						pend_wdata = id;
						meta_we    = 1'b1;
						meta_wdata = meta_t'{head: meta_cur.head, cnt: meta_cur.cnt + CW'(1)};
						if (meta_cur.cnt == '0) begin
							res_d.grant_valid = 1'b1;
							res_d.grant_id    = hpks_pkg::ID_PORT_W'(id);
						end
					end
					state_d = ST_DONE;
				end else if (kind == hpks_pkg::KIND_FIN || kind == hpks_pkg::KIND_ABORT) begin
					// Fetch the head id of a non-empty queue
					if (meta_cur.cnt == '0) begin
						if (kind == hpks_pkg::KIND_FIN) begin
							res_d.status = hpks_pkg::STAT_EMPTY;
						end
						state_d = ST_DONE;
					end else begin
						pend_raddr = slot_addr(bucket, meta_cur.head);
						state_d    = ST_HEAD;
					end
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_HEAD: begin
				if (!keep) begin
					// Pop the matching head and fetch the next one
					meta_we    = 1'b1;
					meta_wdata = meta_t'{head: pop_head, cnt: pop_cnt};
					if (pop_cnt == '0) begin
						state_d = ST_DONE;
					end else begin
						pend_raddr = slot_addr(bucket, pop_head);
						state_d    = ST_NEXT;
					end
				end else if (kind == hpks_pkg::KIND_FIN) begin
					res_d.status = hpks_pkg::STAT_MISMATCH;
					state_d      = ST_DONE;
				end else if (cnt_q == CW'(1)) begin
					state_d = ST_DONE;
				end else begin
					// Head stays; scan the rest of the queue
					pend_raddr = slot_addr(bucket, pop_head);
					idx_d      = CW'(1);
					kept_d     = CW'(1);
					state_d    = ST_SCAN;
				end
			end
			ST_NEXT: begin
				res_d.grant_valid = 1'b1;
				res_d.grant_id    = hpks_pkg::ID_PORT_W'(pend_rdata_q);
				state_d           = ST_DONE;
			end
			ST_SCAN: begin
				// Compact: move each surviving id down to the kept position
				if (keep) begin
					pend_we = 1'b1;
				end
				kept_d = kept_nx;
				if (idx_nx < cnt_q) begin
					pend_raddr = slot_addr(bucket, pos_add(head_q, idx_nx));
					idx_d      = idx_nx;
				end else begin
					meta_we    = 1'b1;
					meta_wdata = meta_t'{head: head_q, cnt: kept_nx};
					state_d    = ST_DONE;
				end
			end
			ST_DONE: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Working values and the result
	always_ff @(posedge clk) begin
		head_q <= head_d;
		cnt_q  <= cnt_d;
		idx_q  <= idx_d;
		kept_q <= kept_d;
		res_q  <= res_d;
	end

	assign res_valid = state_q == ST_DONE;
	assign res       = res_q;

	// Checks
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == ST_IDLE)
		else $error("start while the sequencer is busy");

	a_scan_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> kept_q <= idx_q && idx_q < cnt_q)
		else $error("compaction indexes out of order");

	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && res_q.grant_valid |-> res_q.status == hpks_pkg::STAT_OK)
		else $error("grant with a failure status");

	a_full_enq: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && res_q.status == hpks_pkg::STAT_FULL
			|-> kind == hpks_pkg::KIND_ENQ)
		else $error("queue full reported for a non-enqueue");

	a_no_grant_id: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && !res_q.grant_valid |-> res_q.grant_id == '0)
		else $error("grant id set without a grant");

endmodule

`default_nettype wire

// ===== rtl/core/hashed_per_key_update_serializer_top.sv =====
// For enqueue, an empty queue or an unused kind the sequencer steps from IDLE through META
// to DONE; a finish id mismatch also passes HEAD, a pop that grants the next id passes HEAD
// and NEXT, and an abort that compacts a queue passes HEAD and SCAN (one id slot read per
// cycle). One item at a time; the next is taken the cycle after the result moves into the
// output register. Reset clears the salt, the control state and the per-bucket valid bits
// at once; the id slot memory is not cleared.
// ============================================================================
// hashed_per_key_update_serializer_top: per-key update serializer
// Input and output channels, salt register port, bucket hash and the queue
// sequencer with its output register.
// ============================================================================
`default_nettype none

module hashed_per_key_update_serializer_top #(
	parameter int BUCKET_BITS = 4,
	parameter int QUEUE_DEPTH = 4,
	parameter int ID_BITS     = 8
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire hpks_pkg::in_item_t              in_data,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output hpks_pkg::out_item_t                  out_data,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [hpks_pkg::APB_AW-1:0]     paddr,
	input  wire logic [hpks_pkg::APB_DW-1:0]     pwdata,
	output logic      [hpks_pkg::APB_DW-1:0]     prdata,
	output logic                                 pready
);

	localparam int IDW = (ID_BITS < hpks_pkg::ID_PORT_W) ? ID_BITS : hpks_pkg::ID_PORT_W;

	logic                     in_xfer;
	logic                     busy_q;
	logic                     start_q;
	logic [1:0]               kind_q;
	logic [IDW-1:0]           id_q;
	logic [63:0]              salt_q;
	logic [BUCKET_BITS-1:0]   bucket;
	logic                     res_valid;
	logic                     res_ready;
	hpks_pkg::out_item_t      res;
	logic                     out_valid_q;
	hpks_pkg::out_item_t      out_data_q;
	logic [hpks_pkg::REG_IDX_W-1:0] reg_idx;

	// Register port: write the salt in the access phase
	assign reg_idx = paddr[hpks_pkg::APB_AW-1:3];
	assign pready  = 1'b1;
	assign prdata  = (reg_idx == hpks_pkg::REG_SALT) ? salt_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			salt_q <= '0;
		end else if (psel && penable && pwrite && reg_idx == hpks_pkg::REG_SALT) begin
			salt_q <= pwdata;
		end
	end

	// Input side: take one item, hold it until its result moves on
	assign in_ready = !busy_q;
	assign in_xfer  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			start_q <= 1'b0;
		end else begin
			start_q <= in_xfer;
			if (in_xfer) begin
				busy_q <= 1'b1;
			end else if (res_valid && res_ready) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kind_q <= in_data.kind;
			id_q   <= in_data.update_id[IDW-1:0];
		end
	end

	hpks_hash #(
		.BUCKET_BITS(BUCKET_BITS)
	) u_hash (
		.clk      (clk),
		.load     (in_xfer),
		.key_high (in_data.key_high),
		.key_low  (in_data.key_low),
		.salt     (salt_q),
		.bucket   (bucket)
	);

	hpks_engine #(
		.BUCKET_BITS(BUCKET_BITS),
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.ID_BITS    (ID_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start_q),
		.kind      (kind_q),
		.id        (id_q),
		.bucket    (bucket),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output register: load a result when empty or being drained
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

// ===== test/hashed_per_key_update_serializer_top_tb.sv =====
// ============================================================================
// hashed_per_key_update_serializer_top_tb: self-checking bench of the serializer
// Sends enqueue, finish and abort updates over the input channel under random
// idling on both sides, predicts each grant and status from a local model of
// the bucket queues, and checks every result in order. The salt register is
// rewritten between phases through the register port.
// ============================================================================
`default_nettype none

module hashed_per_key_update_serializer_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BUCKET_BITS = 4;
	localparam int QUEUE_DEPTH = 4;
	localparam int NUM_BUCKETS = 1 << BUCKET_BITS;
	localparam int POOL_KEYS   = 8;
	localparam int DRAIN_SLACK = 12;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	hpks_pkg::in_item_t            in_data;
	logic                          out_valid;
	logic                          out_ready;
	hpks_pkg::out_item_t           out_data;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [hpks_pkg::APB_AW-1:0]   paddr;
	logic [hpks_pkg::APB_DW-1:0]   pwdata;
	logic [hpks_pkg::APB_DW-1:0]   prdata;
	logic                          pready;

	// Local copy of the bucket queues and the salt
	logic [hpks_pkg::ID_PORT_W-1:0] queued_ids [NUM_BUCKETS][QUEUE_DEPTH];
	int unsigned           head_slot [NUM_BUCKETS];
	int unsigned           depth_used [NUM_BUCKETS];
	logic [63:0]           salt_reg;

	hpks_pkg::out_item_t   grant_queue [$];
	int unsigned           error_count;
	int unsigned           cycle_count;
	bit                    stall_on;
	int unsigned           ready_hold;

	logic [63:0]           pool_high [POOL_KEYS];
	logic [63:0]           pool_low [POOL_KEYS];

	hashed_per_key_update_serializer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Fold the salted key into a bucket index
	function automatic int unsigned bucket_of(logic [63:0] key_hi, logic [63:0] key_lo);
		logic [63:0] k;
		logic [63:0] f;
		k = key_hi ^ key_lo ^ salt_reg;
		f = k ^ (k >> (BUCKET_BITS * 12)) ^ (k >> (BUCKET_BITS * 10))
			^ (k >> (BUCKET_BITS * 8)) ^ (k >> (BUCKET_BITS * 6))
			^ (k >> (BUCKET_BITS * 4)) ^ (k >> (BUCKET_BITS * 2));
		return int'(f[BUCKET_BITS-1:0]);
	endfunction

	// Advance the local queues by one update and return the grant it causes
	function automatic hpks_pkg::out_item_t predict_grant(hpks_pkg::in_item_t item);
		hpks_pkg::out_item_t res;
		int unsigned b;
		int unsigned cnt;
		int unsigned kept;
		logic [hpks_pkg::ID_PORT_W-1:0] v;
		res = '0;
		res.status = hpks_pkg::STAT_OK;
		b = bucket_of(item.key_high, item.key_low);
		cnt = depth_used[b];
		kept = 0;
		case (item.kind)
			hpks_pkg::KIND_ENQ: begin
				if (cnt >= QUEUE_DEPTH) begin
					res.status = hpks_pkg::STAT_FULL;
				end else begin
					queued_ids[b][(head_slot[b] + cnt) % QUEUE_DEPTH] = item.update_id;
					depth_used[b] = cnt + 1;
					if (cnt == 0) begin
						res.grant_valid = 1'b1;
						res.grant_id = item.update_id;
					end
				end
			end
			hpks_pkg::KIND_FIN, hpks_pkg::KIND_ABORT: begin
				if (cnt != 0 && queued_ids[b][head_slot[b]] == item.update_id) begin
					// pop the head and grant the next one in line
					head_slot[b] = (head_slot[b] + 1) % QUEUE_DEPTH;
					depth_used[b] = cnt - 1;
					if (depth_used[b] != 0) begin
						res.grant_valid = 1'b1;
						res.grant_id = queued_ids[b][head_slot[b]];
					end
				end else if (item.kind == hpks_pkg::KIND_FIN) begin
					res.status = (cnt == 0) ? hpks_pkg::STAT_EMPTY : hpks_pkg::STAT_MISMATCH;
				end else begin
					// drop every copy of the id, keep order of the rest
					for (int i = 0; i < cnt; i++) begin
						v = queued_ids[b][(head_slot[b] + i) % QUEUE_DEPTH];
						if (v != item.update_id) begin
							queued_ids[b][(head_slot[b] + kept) % QUEUE_DEPTH] = v;
							kept++;
						end
					end
					depth_used[b] = kept;
				end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	task automatic report_field(string field, logic [63:0] exp_val, logic [63:0] got_val);
		if (got_val !== exp_val) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, exp_val,
				got_val);
			error_count++;
		end
	endtask

	// Check result transfers against the oldest grant, then record new updates
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (grant_queue.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual %0h", $time,
						out_data);
					error_count++;
				end else begin
					report_field("grant_valid", grant_queue[0].grant_valid, out_data.grant_valid);
					report_field("grant_id", grant_queue[0].grant_id, out_data.grant_id);
					report_field("status", grant_queue[0].status, out_data.status);
					void'(grant_queue.pop_front());
				end
			end
			if (in_valid && in_ready)
				grant_queue.push_back(predict_grant(in_data));
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("hashed_per_key_update_serializer_top_tb: FAIL");
			$finish;
		end
	end

	// Result-side backpressure: stall bursts and calm stretches
	initial begin
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (!stall_on) begin
				out_ready <= 1'b1;
				ready_hold = 0;
			end else if (ready_hold > 0) begin
				ready_hold--;
			end else if ($urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				ready_hold = $urandom_range(1, 12) - 1;
			end else if ($urandom_range(0, 15) == 0) begin
				out_ready <= 1'b1;
				ready_hold = $urandom_range(20, 60);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic hpks_pkg::in_item_t make_update(logic [1:0] kind, logic [63:0] key_hi,
		logic [63:0] key_lo, logic [hpks_pkg::ID_PORT_W-1:0] id);
		hpks_pkg::in_item_t item;
		item.kind = kind;
		item.key_high = key_hi;
		item.key_low = key_lo;
		item.update_id = id;
		return item;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Favor a few small ids so duplicates and matches are common
	function automatic logic [hpks_pkg::ID_PORT_W-1:0] pick_id();
		if ($urandom_range(0, 1) == 0)
			return hpks_pkg::ID_PORT_W'($urandom_range(0, 7));
		return hpks_pkg::ID_PORT_W'($urandom);
	endfunction

	// Build the next random update, mostly well formed against the known queues
	function automatic hpks_pkg::in_item_t next_update();
		hpks_pkg::in_item_t item;
		int unsigned p;
		int unsigned b;
		int unsigned cnt;
		int unsigned r;
		p = $urandom_range(0, POOL_KEYS - 1);
		item = make_update(hpks_pkg::KIND_ENQ, pool_high[p], pool_low[p], pick_id());
		if ($urandom_range(0, 9) == 0) begin
			// noise: any key, any kind
			item.key_high = rand64();
			item.key_low = rand64();
			item.kind = 2'($urandom);
			return item;
		end
		b = bucket_of(item.key_high, item.key_low);
		cnt = depth_used[b];
		r = $urandom_range(0, 99);
		if (r < 45) begin
			item.kind = hpks_pkg::KIND_ENQ;
		end else if (r < 75) begin
			item.kind = hpks_pkg::KIND_FIN;
			if (cnt != 0 && $urandom_range(0, 4) != 0)
				item.update_id = queued_ids[b][head_slot[b]];
		end else if (r < 96) begin
			item.kind = hpks_pkg::KIND_ABORT;
			if (cnt != 0 && $urandom_range(0, 3) != 0)
				item.update_id =
					queued_ids[b][(head_slot[b] + $urandom_range(0, cnt - 1)) % QUEUE_DEPTH];
		end else begin
			item.kind = KIND_UNUSED;
		end
		return item;
	endfunction

	// Present one update and hold it until the transfer
	task automatic send_update(hpks_pkg::in_item_t item);
		in_valid <= 1'b1;
		in_data <= item;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Drop valid for a random burst now and then
	task automatic idle_gap();
		if (stall_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
	endtask

	// Hold off until every pending grant has arrived
	task automatic wait_results_drained();
		in_valid <= 1'b0;
		while (grant_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_SLACK) @(negedge clk);
	endtask

	// Write the salt through a setup and an access cycle
	task automatic write_salt(logic [63:0] value);
		wait_results_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {hpks_pkg::REG_SALT, 3'b000};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		salt_reg = value;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Walk the special cases on two fixed buckets
	task automatic test_directed_cases();
		logic [63:0] ones;
		ones = '1;
		write_salt('0);
		send_update(make_update(hpks_pkg::KIND_FIN, '0, '0, 8'h05));
		send_update(make_update(hpks_pkg::KIND_ABORT, '0, '0, 8'h05));
		send_update(make_update(hpks_pkg::KIND_ENQ, '0, '0, 8'h00));
		send_update(make_update(hpks_pkg::KIND_ENQ, '0, '0, 8'hFF));
		send_update(make_update(hpks_pkg::KIND_ENQ, '0, '0, 8'h33));
		send_update(make_update(hpks_pkg::KIND_ENQ, '0, '0, 8'hFF));
		send_update(make_update(hpks_pkg::KIND_ENQ, '0, '0, 8'h11));
		send_update(make_update(hpks_pkg::KIND_FIN, '0, '0, 8'hFF));
		send_update(make_update(hpks_pkg::KIND_ABORT, '0, '0, 8'hFF));
		send_update(make_update(KIND_UNUSED, ones, ones, 8'hFF));
		send_update(make_update(hpks_pkg::KIND_FIN, '0, '0, 8'h00));
		send_update(make_update(hpks_pkg::KIND_ABORT, '0, '0, 8'h33));
		send_update(make_update(hpks_pkg::KIND_ABORT, '0, '0, 8'h77));
		send_update(make_update(hpks_pkg::KIND_ENQ, ones, '0, 8'hAA));
		send_update(make_update(hpks_pkg::KIND_ENQ, ones, '0, 8'h55));
		send_update(make_update(hpks_pkg::KIND_ABORT, ones, '0, 8'hAA));
		send_update(make_update(hpks_pkg::KIND_FIN, ones, '0, 8'h55));
		send_update(make_update(hpks_pkg::KIND_ENQ, ones, ones, 8'h80));
		send_update(make_update(hpks_pkg::KIND_FIN, ones, ones, 8'h80));
		send_update(make_update(hpks_pkg::KIND_ENQ, '0, ones, 8'h7F));
		send_update(make_update(hpks_pkg::KIND_ABORT, '0, ones, 8'h7F));
		in_valid <= 1'b0;
	endtask

	// Random traffic on a fresh pool of keys under one salt
	task automatic test_random_traffic(logic [63:0] salt, int unsigned count);
		write_salt(salt);
		for (int i = 0; i < POOL_KEYS; i++) begin
			pool_high[i] = rand64();
			pool_low[i] = rand64();
		end
		for (int n = 0; n < count; n++) begin
			send_update(next_update());
			idle_gap();
		end
		in_valid <= 1'b0;
	endtask

	// Pause the sender until all grants are back, then resume on the same queues
	task automatic test_drain_pause(int unsigned count);
		for (int n = 0; n < count; n++) begin
			send_update(next_update());
			idle_gap();
		end
		wait_results_drained();
		for (int n = 0; n < count; n++) begin
			send_update(next_update());
			idle_gap();
		end
		in_valid <= 1'b0;
	endtask

	// Main sequence
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		salt_reg = '0;
		error_count = 0;
		cycle_count = 0;
		stall_on = 1'b1;
		ready_hold = 0;
		for (int b = 0; b < NUM_BUCKETS; b++) begin
			head_slot[b] = 0;
			depth_used[b] = 0;
			for (int s = 0; s < QUEUE_DEPTH; s++)
				queued_ids[b][s] = '0;
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (4) @(negedge clk);

		test_directed_cases();
		test_random_traffic('1, 200);
		test_drain_pause(30);
		test_random_traffic(rand64(), 200);
		test_random_traffic('0, 150);
		stall_on = 1'b0;
		test_random_traffic(rand64(), 200);

		wait_results_drained();
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("hashed_per_key_update_serializer_top_tb: PASS");
		else
			$display("hashed_per_key_update_serializer_top_tb: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
